### rtl/core/ils_pkg.sv
// Shared types and constants for the indexed list store.
// No dependencies.
`default_nettype none
package ils_pkg;
  localparam int unsigned CAPACITY_DEF = 256;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0, ACT_ERASE = 3'd1, ACT_READ = 3'd2, ACT_FIND = 3'd3,
    ACT_ERASE_MULT = 3'd4, ACT_ODD_FIRST = 3'd5, ACT_REVERSE = 3'd6, ACT_NONE = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BAD_INDEX = 3'd1, ST_FULL = 3'd2, ST_NOT_FOUND = 3'd3,
    ST_ZERO_DIV = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [8:0]  position;
    logic [31:0] value;
    logic [31:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [7:0]  found_position;
    logic [8:0]  length_after;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDW, S_WR, S_DIV, S_EVN, S_EVW, S_OUT
  } state_e;

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    magnitude = v[31] ? (32'd0 - v) : v;
  endfunction
endpackage
`default_nettype wire

### rtl/core/ils_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module ils_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/ils_divu.sv
// Radix-2 restoring remainder unit, one bit per cycle.
// Depends on nothing outside itself.
`default_nettype none
module ils_divu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic             zero_rem_o
);
  logic [31:0] num_q, num_d, den_q, den_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] trial;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  // shift in one dividend bit per cycle
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, num_q[31]} - {1'b0, den_q};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      rem_d = trial[32] ? {rem_q[30:0], num_q[31]} : trial[31:0];
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o     = busy_q && (cnt_q == 6'd1) && !start_i;
  assign zero_rem_o = (trial[32] ? {rem_q[30:0], num_q[31]} : trial[31:0]) == 32'd0;
endmodule
`default_nettype wire

### rtl/core/indexed_list_store.sv
// Indexed list store: ordered list of signed 32-bit entries in on-chip RAM.
// Read issues one RAM read; insert, erase, find and reverse step through each entry
// moved or scanned; erase multiples runs the remainder unit on each entry; odd first
// scans each entry, then copies each even one back from the scratch RAM.
// One item at a time: the next beat is taken in the cycle after the result leaves.
// Reset clears length and control; RAM contents are undefined until written.
`default_nettype none
module indexed_list_store #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned LW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ils_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ils_pkg::out_item_t     out_data_o
);
  ils_pkg::state_e state_q, state_d;
  ils_pkg::in_item_t req_q, req_d;
  ils_pkg::out_item_t res_q, res_d;
  logic [LW-1:0] len_q, len_d, i_q, i_d, k_q, k_d, n_q, n_d, j_q, j_d;
  logic [31:0] hold_q, hold_d;
  logic        pass_q, pass_d;   // reverse: first of the pair is held, partner read next
  logic        we, swe, dstart, ddone, dzero;
  logic [AW-1:0] waddr, raddr, saddr_w, saddr_r;
  logic [31:0] wdata, rdata, srdata, swdata;
  logic [LW-1:0] pos;

  ils_ram #(.Width(32), .Depth(CAPACITY)) u_main (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata));
  ils_ram #(.Width(32), .Depth(CAPACITY)) u_scr (
    .clk_i, .we_i(swe), .waddr_i(saddr_w), .wdata_i(swdata),
    .raddr_i(saddr_r), .rdata_o(srdata));
  ils_divu u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(ils_pkg::magnitude(rdata)),
    .den_i(ils_pkg::magnitude(req_q.divisor)), .done_o(ddone), .zero_rem_o(dzero));

  assign pos         = LW'(req_q.position);
  assign in_stall_o  = (state_q != ils_pkg::S_IDLE);
  assign out_valid_o = (state_q == ils_pkg::S_OUT);
  assign out_data_o  = res_q;

  // sequencer: next state, counters and RAM strobes
  always_comb begin
    state_d = state_q; req_d = req_q; res_d = res_q; len_d = len_q;
    i_d = i_q; k_d = k_q; n_d = n_q; j_d = j_q; hold_d = hold_q; pass_d = pass_q;
    we = 1'b0; swe = 1'b0; dstart = 1'b0;
    waddr = AW'(k_q); wdata = rdata; raddr = AW'(i_q);
    saddr_w = AW'(n_q); swdata = rdata; saddr_r = AW'(j_q);
    unique case (state_q)
      ils_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          res_d = '0;
          res_d.length_after = 9'(len_q);
          pass_d = 1'b0; n_d = '0; j_d = '0;
          state_d = ils_pkg::S_OUT;
          unique case (ils_pkg::action_e'(in_data_i.action))
            ils_pkg::ACT_INSERT: begin
              if (32'(in_data_i.position) > 32'(len_q)) res_d.status = ils_pkg::ST_BAD_INDEX;
              else if (len_q == LW'(CAPACITY)) res_d.status = ils_pkg::ST_FULL;
              else begin
                i_d = len_q; k_d = len_q; state_d = ils_pkg::S_RD;
              end
            end
            ils_pkg::ACT_ERASE, ils_pkg::ACT_READ: begin
              if (32'(in_data_i.position) >= 32'(len_q))
                res_d.status = ils_pkg::ST_BAD_INDEX;
              else begin
                i_d = LW'(in_data_i.position); k_d = LW'(in_data_i.position);
                state_d = ils_pkg::S_RD;
              end
            end
            ils_pkg::ACT_FIND: begin
              res_d.status = ils_pkg::ST_NOT_FOUND;
              i_d = '0;
              if (len_q != '0) state_d = ils_pkg::S_RD;
            end
            ils_pkg::ACT_ERASE_MULT: begin
              if (in_data_i.divisor == '0) res_d.status = ils_pkg::ST_ZERO_DIV;
              else begin
                i_d = '0; k_d = '0;
                if (len_q != '0) state_d = ils_pkg::S_RD;
              end
            end
            ils_pkg::ACT_ODD_FIRST: begin
              i_d = '0; k_d = '0;
              if (len_q != '0) state_d = ils_pkg::S_RD;
            end
            ils_pkg::ACT_REVERSE: begin
              i_d = '0; k_d = len_q - LW'(1);
              if (len_q > LW'(1)) state_d = ils_pkg::S_RD;
            end
            default: ;
          endcase
        end
      end
      // issue read of entry i (i-1 for insert, i+1 for erase), or finish insert/erase
      ils_pkg::S_RD: begin
        unique case (ils_pkg::action_e'(req_q.action))
          ils_pkg::ACT_INSERT: raddr = AW'(i_q - LW'(1));
          ils_pkg::ACT_ERASE:  raddr = AW'(i_q + LW'(1));
          default:             raddr = AW'(i_q);
        endcase
        state_d = ils_pkg::S_RDW;
        if (ils_pkg::action_e'(req_q.action) == ils_pkg::ACT_INSERT && i_q == pos) begin
          // gap open: drop the new value in
          we = 1'b1; waddr = AW'(pos); wdata = req_q.value;
          len_d = len_q + LW'(1); res_d.length_after = 9'(len_q + LW'(1));
          state_d = ils_pkg::S_OUT;
        end else if (ils_pkg::action_e'(req_q.action) == ils_pkg::ACT_ERASE
                     && i_q + LW'(1) == len_q) begin
          len_d = len_q - LW'(1); res_d.length_after = 9'(len_q - LW'(1));
          state_d = ils_pkg::S_OUT;
        end
      end
      ils_pkg::S_RDW: begin
        unique case (ils_pkg::action_e'(req_q.action))
          ils_pkg::ACT_INSERT: begin
            we = 1'b1; waddr = AW'(i_q); i_d = i_q - LW'(1); state_d = ils_pkg::S_RD;
          end
          ils_pkg::ACT_ERASE: begin
            we = 1'b1; waddr = AW'(i_q); i_d = i_q + LW'(1); state_d = ils_pkg::S_RD;
          end
          ils_pkg::ACT_READ: begin
            res_d.read_data = rdata; state_d = ils_pkg::S_OUT;
          end
          ils_pkg::ACT_FIND: begin
            if (rdata == req_q.value) begin
              res_d.status = ils_pkg::ST_OK; res_d.found_position = 8'(i_q);
              state_d = ils_pkg::S_OUT;
            end else if (i_q + LW'(1) == len_q) state_d = ils_pkg::S_OUT;
            else begin
              i_d = i_q + LW'(1); state_d = ils_pkg::S_RD;
            end
          end
          ils_pkg::ACT_ERASE_MULT: begin
            hold_d = rdata; dstart = 1'b1; state_d = ils_pkg::S_DIV;
          end
          ils_pkg::ACT_ODD_FIRST: begin
            if (rdata[0]) begin
              we = 1'b1; waddr = AW'(k_q); k_d = k_q + LW'(1);
            end else begin
              swe = 1'b1; n_d = n_q + LW'(1);
            end
            if (i_q + LW'(1) == len_q) begin
              if (n_d == '0) state_d = ils_pkg::S_OUT;
              else state_d = ils_pkg::S_EVN;
            end else begin
              i_d = i_q + LW'(1); state_d = ils_pkg::S_RD;
            end
          end
          ils_pkg::ACT_REVERSE: begin
            // first of pair held, then fetch the partner
            if (!pass_q) begin
              hold_d = rdata; pass_d = 1'b1; raddr = AW'(k_q); state_d = ils_pkg::S_WR;
            end
          end
          default: state_d = ils_pkg::S_OUT;
        endcase
      end
      ils_pkg::S_WR: begin
        // reverse: rdata holds entry k, hold holds entry i
        we = 1'b1; waddr = AW'(i_q); wdata = rdata;
        state_d = ils_pkg::S_EVW;
      end
      ils_pkg::S_EVW: begin
        if (ils_pkg::action_e'(req_q.action) == ils_pkg::ACT_REVERSE) begin
          we = 1'b1; waddr = AW'(k_q); wdata = hold_q; pass_d = 1'b0;
          if (i_q + LW'(2) >= k_q) state_d = ils_pkg::S_OUT;
          else begin
            i_d = i_q + LW'(1); k_d = k_q - LW'(1); state_d = ils_pkg::S_RD;
          end
        end else begin
          // odd first: copy one even back from scratch
          we = 1'b1; waddr = AW'(k_q); wdata = srdata; k_d = k_q + LW'(1);
          j_d = j_q + LW'(1);
          state_d = (j_q + LW'(1) == n_q) ? ils_pkg::S_OUT : ils_pkg::S_EVN;
        end
      end
      ils_pkg::S_EVN: begin
        saddr_r = AW'(j_q); state_d = ils_pkg::S_EVW;
      end
      ils_pkg::S_DIV: begin
        if (ddone) begin
          if (!dzero) begin
            we = 1'b1; waddr = AW'(k_q); wdata = hold_q; k_d = k_q + LW'(1);
          end
          if (i_q + LW'(1) == len_q) begin
            len_d = dzero ? k_q : k_q + LW'(1);
            res_d.length_after = 9'(len_d);
            state_d = ils_pkg::S_OUT;
          end else begin
            i_d = i_q + LW'(1); state_d = ils_pkg::S_RD;
          end
        end
      end
      ils_pkg::S_OUT: if (!out_stall_i) state_d = ils_pkg::S_IDLE;
      default: state_d = ils_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ils_pkg::S_IDLE;
      len_q   <= '0;
      i_q <= '0; k_q <= '0; n_q <= '0; j_q <= '0; pass_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      i_q <= i_d; k_q <= k_d; n_q <= n_d; j_q <= j_d; pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    hold_q <= hold_d;
  end
endmodule
`default_nettype wire

### rtl/core/ils_checker.sv
// Port-level checks for the indexed list store.
// Depends on ils_pkg; bound to indexed_list_store.
`default_nettype none
module ils_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire ils_pkg::out_item_t out_data_o
);
  // no new beat is taken while a result is pending
  a_stall_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken with result pending");
  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  // status code in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ils_pkg::ST_ZERO_DIV)
    else $error("bad status code");
  // an accepted beat leads to stall next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("not busy after accept");
endmodule

bind indexed_list_store ils_checker u_ils_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o);
`default_nettype wire
